// ===== rtl/ssa_pkg.sv =====
// types, codes and constants shared by the slot allocator modules
`default_nettype none
package ssa_pkg;

  localparam int MAX_SECTIONS_DEF      = 16;
  localparam int SLOTS_PER_SECTION_DEF = 256;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 32;
  localparam int OUT_ADDR_W = 24;
  localparam int ES_W       = 13;
  localparam int CAP_W      = 9;
  localparam int ES_MAX     = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_DISPOSE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  localparam logic REG_ELEMENT_SIZE     = 1'b0;
  localparam logic REG_SECTION_CAPACITY = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SWEEP,
    DP_CLEAR,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_OPEN,
    DP_TAKE,
    DP_POP,
    DP_MARK,
    DP_MULT,
    DP_DIV_GO,
    DP_WAIT,
    DP_CHK_ADDR,
    DP_SPLIT,
    DP_RD_OCC,
    DP_DISP,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_OPEN,
    ST_TAKE,
    ST_POP,
    ST_MARK,
    ST_MULT,
    ST_DIV_ADDR,
    ST_CHK_ADDR,
    ST_DIV_SPLIT,
    ST_SPLIT,
    ST_RD_OCC,
    ST_DISP,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    op_code_t op;
    logic     scan_hit;
    logic     scan_last;
    logic     pool_full;
    logic     has_free;
    logic     div_done;
    logic     addr_bad;
    logic     sweep_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ssa_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module ssa_div import ssa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] dividend,
  input  wire logic [ES_W-1:0]   divisor,
  output logic                   done,
  output logic [ADDR_W-1:0]      quotient,
  output logic [ES_W-1:0]        remainder
);

  localparam int CW = $clog2(ADDR_W);

  logic [ADDR_W-1:0] qr;
  logic [ES_W-1:0]   rem;
  logic [ES_W-1:0]   dv;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [ES_W:0]     trial;
  logic              fits;

  assign trial = {rem, qr[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      qr  <= {qr[ADDR_W-2:0], fits};
      rem <= fits ? ES_W'(trial - {1'b0, dv}) : ES_W'(trial);
    end
  end

  assign quotient  = qr;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== rtl/ssa_dp.sv =====
// allocator datapath: section counters, occupancy and free stack memories, address maths
`default_nettype none
module ssa_dp import ssa_pkg::*; #(
  parameter int MaxSections     = MAX_SECTIONS_DEF,
  parameter int SlotsPerSection = SLOTS_PER_SECTION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [ADDR_W-1:0]     in_addr,
  input  wire logic [ES_W-1:0]       es,
  input  wire logic [$clog2(SlotsPerSection+1)-1:0] cap,
  output logic [1:0]                 out_status,
  output logic [OUT_ADDR_W-1:0]      out_addr,
  output logic                       out_already
);

  localparam int SW   = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int KW   = (SlotsPerSection > 1) ? $clog2(SlotsPerSection) : 1;
  localparam int TOT  = MaxSections * SlotsPerSection;
  localparam int IW   = (TOT > 1) ? $clog2(TOT) : 1;
  localparam int CNTW = $clog2(SlotsPerSection + 1);
  localparam int OW   = $clog2(MaxSections + 1);
  localparam int LW   = OW + CNTW;
  localparam int PW   = IW + ES_W;

  logic            occ_mem [TOT];
  logic [KW-1:0]   stk_mem [TOT];
  logic            occ_q;
  logic [KW-1:0]   stk_q;

  logic [CNTW-1:0] init_cnt [MaxSections];
  logic [CNTW-1:0] free_cnt [MaxSections];
  logic [OW-1:0]   n_open;
  logic [SW-1:0]   ss;
  logic [SW-1:0]   sw_sec;
  logic [KW-1:0]   sw_k;

  op_code_t        op_reg;
  logic [ADDR_W-1:0] addr_reg;
  logic [SW-1:0]   s_reg;
  logic [KW-1:0]   slot_reg;
  logic [IW-1:0]   lin;
  logic [LW-1:0]   lim;
  logic [SW-1:0]   scan_c;
  logic [OW-1:0]   scan_cnt;
  status_t         res_status;
  logic [OUT_ADDR_W-1:0] res_addr;
  logic            res_already;

  logic [CNTW-1:0] free_s, init_s, free_c, init_c;
  logic [IW-1:0]   base, occ_ra, stk_ra, push_wa, sweep_wa;
  logic            hit, last, full, bad, sweep_last;
  logic            occ_we, occ_wd, stk_we;
  logic [IW-1:0]   occ_wa, stk_wa;
  logic [KW-1:0]   stk_wd;
  logic [PW-1:0]   prod;

  logic            div_start, div_done;
  logic [ADDR_W-1:0] div_q, div_dividend;
  logic [ES_W-1:0] div_r, div_divisor;

  assign free_s   = free_cnt[s_reg];
  assign init_s   = init_cnt[s_reg];
  assign free_c   = free_cnt[scan_c];
  assign init_c   = init_cnt[scan_c];
  assign base     = IW'(int'(s_reg) * SlotsPerSection);
  assign occ_ra   = base + IW'(slot_reg);
  assign stk_ra   = base + IW'(free_s - 1'b1);
  assign push_wa  = base + IW'(free_s);
  assign sweep_wa = IW'(int'(sw_sec) * SlotsPerSection) + IW'(sw_k);

  assign hit  = (n_open != '0) && ((free_c != '0) || (init_c < cap));
  assign last = (n_open == '0) || (scan_cnt == n_open - 1'b1);
  assign full = n_open == OW'(MaxSections);
  assign bad  = (div_r != '0) || (div_q >= ADDR_W'(lim));
  assign sweep_last = (sw_sec == SW'(MaxSections - 1)) && (sw_k == KW'(SlotsPerSection - 1));
  assign prod = PW'(lin) * PW'(es);

  assign sts.op         = op_reg;
  assign sts.scan_hit   = hit;
  assign sts.scan_last  = last;
  assign sts.pool_full  = full;
  assign sts.has_free   = free_s != '0;
  assign sts.div_done   = div_done;
  assign sts.addr_bad   = bad;
  assign sts.sweep_last = sweep_last;

  // first pass divides by element size, second by section capacity
  assign div_start    = (cmd.op == DP_DIV_GO) || ((cmd.op == DP_CHK_ADDR) && !bad);
  assign div_dividend = (cmd.op == DP_DIV_GO) ? addr_reg : div_q;
  assign div_divisor  = (cmd.op == DP_DIV_GO) ? es : ES_W'(cap);

  ssa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    occ_we = 1'b0;
    occ_wd = 1'b0;
    occ_wa = occ_ra;
    stk_we = 1'b0;
    stk_wa = push_wa;
    stk_wd = slot_reg;
    unique case (cmd.op)
      DP_SWEEP: begin
        occ_we = 1'b1;
        occ_wa = sweep_wa;
        stk_we = 1'b1;
        stk_wa = sweep_wa;
        stk_wd = sw_k;
      end
      DP_MARK: begin
        occ_we = 1'b1;
        occ_wd = 1'b1;
      end
      DP_DISP: begin
        occ_we = occ_q;
        stk_we = occ_q && (free_s < CNTW'(SlotsPerSection));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_q <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_open <= '0;
      ss     <= '0;
      sw_sec <= '0;
      sw_k   <= '0;
      for (int i = 0; i < MaxSections; i++) begin
        init_cnt[i] <= '0;
        free_cnt[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        DP_SWEEP: begin
          if (sw_k == KW'(SlotsPerSection - 1)) begin
            sw_k   <= '0;
            sw_sec <= sw_sec + 1'b1;
          end else begin
            sw_k <= sw_k + 1'b1;
          end
        end
        DP_CLEAR: begin
          for (int i = 0; i < MaxSections; i++) free_cnt[i] <= init_cnt[i];
          ss     <= '0;
          sw_sec <= '0;
          sw_k   <= '0;
        end
        DP_OPEN: begin
          init_cnt[SW'(n_open)] <= '0;
          free_cnt[SW'(n_open)] <= '0;
          n_open <= n_open + 1'b1;
        end
        DP_TAKE: begin
          if (free_s != '0) free_cnt[s_reg] <= free_s - 1'b1;
          else init_cnt[s_reg] <= init_s + 1'b1;
        end
        DP_MARK: ss <= s_reg;
        DP_DISP: begin
          if (occ_q) begin
            if (free_s < CNTW'(SlotsPerSection)) free_cnt[s_reg] <= free_s + 1'b1;
            ss <= s_reg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        op_reg      <= op_code_t'(in_op);
        addr_reg    <= in_addr;
        res_status  <= STAT_OK;
        res_addr    <= '0;
        res_already <= 1'b0;
      end
      DP_SCAN_INIT: begin
        scan_c   <= ss;
        scan_cnt <= '0;
      end
      DP_SCAN: begin
        if (hit) begin
          s_reg <= scan_c;
        end else if (last) begin
          if (full) res_status <= STAT_FULL;
        end else begin
          scan_c   <= (OW'(scan_c) + 1'b1 == n_open) ? '0 : scan_c + 1'b1;
          scan_cnt <= scan_cnt + 1'b1;
        end
      end
      DP_OPEN: s_reg <= SW'(n_open);
      DP_TAKE: begin
        if (free_s == '0) slot_reg <= KW'(init_s);
      end
      DP_POP:  slot_reg <= stk_q;
      DP_MARK: lin <= IW'(int'(s_reg) * int'(cap) + int'(slot_reg));
      DP_MULT: res_addr <= OUT_ADDR_W'(prod);
      DP_DIV_GO: lim <= LW'(n_open) * LW'(cap);
      DP_CHK_ADDR: begin
        if (bad) res_status <= STAT_INVALID;
      end
      DP_SPLIT: begin
        s_reg    <= SW'(div_q);
        slot_reg <= KW'(div_r);
      end
      DP_DISP: begin
        if (!occ_q) res_already <= 1'b1;
      end
      DP_EMIT: begin
        out_status  <= res_status;
        out_addr    <= res_addr;
        out_already <= res_already;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ssa_ctrl.sv =====
// allocator sequencer and request/result handshakes
`default_nettype none
module ssa_ctrl import ssa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == DP_EMIT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    unique case (state)
      ST_INIT: begin
        cmd.op = DP_SWEEP;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = DP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.op)
          OP_ALLOC: begin
            cmd.op     = DP_SCAN_INIT;
            state_next = ST_SCAN;
          end
          OP_DISPOSE: begin
            cmd.op     = DP_DIV_GO;
            state_next = ST_DIV_ADDR;
          end
          OP_CLEAR: begin
            cmd.op     = DP_CLEAR;
            state_next = ST_CLEAR;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        cmd.op = DP_SCAN;
        priority if (sts.scan_hit) state_next = ST_TAKE;
        else if (sts.scan_last && sts.pool_full) state_next = ST_DONE;
        else if (sts.scan_last) state_next = ST_OPEN;
        else state_next = ST_SCAN;
      end
      ST_OPEN: begin
        cmd.op     = DP_OPEN;
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        cmd.op     = DP_TAKE;
        state_next = sts.has_free ? ST_POP : ST_MARK;
      end
      ST_POP: begin
        cmd.op     = DP_POP;
        state_next = ST_MARK;
      end
      ST_MARK: begin
        cmd.op     = DP_MARK;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.op     = DP_MULT;
        state_next = ST_DONE;
      end
      ST_DIV_ADDR: begin
        cmd.op = DP_WAIT;
        if (sts.div_done) state_next = ST_CHK_ADDR;
      end
      ST_CHK_ADDR: begin
        cmd.op     = DP_CHK_ADDR;
        state_next = sts.addr_bad ? ST_DONE : ST_DIV_SPLIT;
      end
      ST_DIV_SPLIT: begin
        cmd.op = DP_WAIT;
        if (sts.div_done) state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.op     = DP_SPLIT;
        state_next = ST_RD_OCC;
      end
      ST_RD_OCC: begin
        cmd.op     = DP_RD_OCC;
        state_next = ST_DISP;
      end
      ST_DISP: begin
        cmd.op     = DP_DISP;
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.op = DP_SWEEP;
        if (sts.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          cmd.op     = DP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sectioned_slot_allocator.sv =====
// Sectioned fixed-size slot allocator. One request is worked on at a time; its result
// goes to an output register, so the next request is taken while a result waits.
// Allocate checks one open section per cycle, then possibly opens a section, reads the
// free stack if it holds a slot and multiplies out the address. Dispose makes up to two
// passes of a 32-step bit-serial divider (address by element size, then index by section
// capacity). Clear sweeps the memories, one memory entry per cycle. After reset the
// occupancy memory (MaxSections*SlotsPerSection entries, 4096 by default) is swept
// before the first request is taken; configuration writes are taken at any time.
`default_nettype none
module sectioned_slot_allocator import ssa_pkg::*; #(
  parameter int MaxSections     = MAX_SECTIONS_DEF,
  parameter int SlotsPerSection = SLOTS_PER_SECTION_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // address[31:0]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // alloc_address[23:0], already_free[24], zero[31:25]
  output logic [1:0]       m_tuser,   // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int CNTW = $clog2(SlotsPerSection + 1);

  logic [ES_W-1:0]  element_size;
  logic [CAP_W-1:0] section_capacity;
  logic [ES_W-1:0]  es;
  logic [CNTW-1:0]  cap;

  cmd_t cmd;
  sts_t sts;

  logic [1:0]            out_status;
  logic [OUT_ADDR_W-1:0] out_addr;
  logic                  out_already;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_size     <= ES_W'(16);
      section_capacity <= CAP_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ELEMENT_SIZE:     element_size     <= cfg_data;
        REG_SECTION_CAPACITY: section_capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // out-of-range register values are clamped
  always_comb begin
    priority if (element_size == '0) es = ES_W'(1);
    else if (element_size > ES_W'(ES_MAX)) es = ES_W'(ES_MAX);
    else es = element_size;
    priority if (section_capacity == '0) cap = CNTW'(1);
    else if (int'(section_capacity) > SlotsPerSection) cap = CNTW'(SlotsPerSection);
    else cap = CNTW'(section_capacity);
  end

  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssa_dp #(
    .MaxSections     (MaxSections),
    .SlotsPerSection (SlotsPerSection)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_addr     (s_tdata),
    .es          (es),
    .cap         (cap),
    .out_status  (out_status),
    .out_addr    (out_addr),
    .out_already (out_already)
  );

  assign m_tdata = {7'b0, out_already, out_addr};
  assign m_tuser = out_status;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_EMIT |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in progress");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> cmd.op == DP_WAIT)
    else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

// ===== test/ssa_checker.sv =====
// checker: predicts allocator results from observed requests and compares them
`timescale 1ns / 100ps
`default_nettype none
module ssa_checker import ssa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               seen_full,
  output int               seen_invalid,
  output int               seen_already
);

  localparam int NSEC  = MAX_SECTIONS_DEF;
  localparam int NSLOT = SLOTS_PER_SECTION_DEF;

  typedef struct packed {
    status_t     status;
    logic [23:0] addr;
    logic        already;
  } alloc_result_t;

  alloc_result_t result_q[$];

  logic [12:0] elem_size;
  logic [8:0]  sec_cap;
  bit          occupied [NSEC*NSLOT];
  int          free_stack [NSEC*NSLOT];
  int          inited [NSEC];
  int          free_cnt [NSEC];
  int          open_cnt;
  int          search_from;

  function automatic longint eff_size();
    if (elem_size == 0) return 1;
    if (elem_size > ES_MAX) return ES_MAX;
    return elem_size;
  endfunction

  function automatic longint eff_cap();
    if (sec_cap == 0) return 1;
    if (sec_cap > NSLOT) return NSLOT;
    return sec_cap;
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [31:0] address);
    alloc_result_t r;
    longint es, cap, sb, a;
    int s, slot, c;
    bit found;
    r = '0;
    es = eff_size();
    cap = eff_cap();
    a = address;
    case (op)
      OP_ALLOC: begin
        found = 0;
        s = 0;
        for (int off = 0; off < open_cnt && !found; off++) begin
          c = ((search_from % open_cnt) + off) % open_cnt;
          if (free_cnt[c] > 0 || inited[c] < cap) begin
            s = c;
            found = 1;
          end
        end
        if (!found && open_cnt >= NSEC) begin
          r.status = STAT_FULL;
        end else begin
          if (!found) begin
            s = open_cnt;
            inited[s] = 0;
            free_cnt[s] = 0;
            open_cnt++;
          end
          if (free_cnt[s] > 0) begin
            free_cnt[s]--;
            slot = free_stack[s*NSLOT + free_cnt[s]];
          end else begin
            slot = inited[s];
            inited[s]++;
          end
          if (slot >= NSLOT) slot = NSLOT - 1;
          occupied[s*NSLOT + slot] = 1;
          search_from = s;
          r.addr = 24'((s * cap + slot) * es);
        end
      end
      OP_DISPOSE: begin
        sb = cap * es;
        if (a >= open_cnt * sb || (a % es) != 0) begin
          r.status = STAT_INVALID;
        end else begin
          s = int'(a / sb);
          slot = int'((a % sb) / es);
          if (!occupied[s*NSLOT + slot]) begin
            r.already = 1;
          end else begin
            occupied[s*NSLOT + slot] = 0;
            if (free_cnt[s] < NSLOT) begin
              free_stack[s*NSLOT + free_cnt[s]] = slot;
              free_cnt[s]++;
            end
            search_from = s;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NSEC*NSLOT; i++) occupied[i] = 0;
        for (int i = 0; i < NSEC; i++) begin
          for (int k = 0; k < inited[i]; k++) free_stack[i*NSLOT + k] = k;
          free_cnt[i] = inited[i];
        end
        search_from = 0;
      end
      default: ;
    endcase
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (rst) begin
      elem_size <= 13'd16;
      sec_cap <= 9'd256;
      for (int i = 0; i < NSEC*NSLOT; i++) begin
        occupied[i] = 0;
        free_stack[i] = 0;
      end
      for (int i = 0; i < NSEC; i++) begin
        inited[i] = 0;
        free_cnt[i] = 0;
      end
      open_cnt = 0;
      search_from = 0;
      result_q.delete();
      fail_count <= 0;
      seen_full <= 0;
      seen_invalid <= 0;
      seen_already <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ELEMENT_SIZE) elem_size <= cfg_data;
        else sec_cap <= 9'(cfg_data);
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.addr = m_tdata[23:0];
        got.already = m_tdata[24];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr=%h", $time, m_tuser, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r || m_tdata[31:25] !== 7'd0) begin
            $display("%0t: mismatch expected status=%0d addr=%h free=%b actual status=%0d addr=%h free=%b",
                     $time, exp_r.status, exp_r.addr, exp_r.already,
                     m_tuser, m_tdata[23:0], m_tdata[24]);
            fail_count <= fail_count + 1;
          end
          if (exp_r.status == STAT_FULL) seen_full <= seen_full + 1;
          if (exp_r.status == STAT_INVALID) seen_invalid <= seen_invalid + 1;
          if (exp_r.already) seen_already <= seen_already + 1;
        end
      end
      // predict after popping so a request that lands in the same cycle queues behind
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
    end
  end

  assign pending = result_q.size();

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench top: drives requests and register writes into the allocator, reports verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ssa_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // address[31:0]
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;        // alloc_address[23:0], already_free[24], zero[31:25]
  logic [1:0]  m_tuser;        // status[1:0]
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [12:0] cfg_data = '0;
  int          fail_count, pending, seen_full, seen_invalid, seen_already;
  int          stall_mode = 0;
  int          sent = 0;
  logic [12:0] cur_size = 13'd16;
  logic [8:0]  cur_cap = 9'd256;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sectioned_slot_allocator dut (.*);

  ssa_checker chk (.*);

  // receiver stalls on its own pattern, with quiet stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_request(input op_code_t op, input logic [31:0] address);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= address;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    s_tvalid <= 1'b0;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // the block may still be on a request after the last result; clear is longest
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ELEMENT_SIZE) cur_size = value;
    else cur_cap = 9'(value);
  endtask

  // a mostly plausible dispose address for the current layout
  function automatic logic [31:0] pick_address();
    int es, cap;
    es = (cur_size == 0) ? 1 : (cur_size > ES_MAX ? ES_MAX : cur_size);
    cap = (cur_cap == 0) ? 1 : (cur_cap > 256 ? 256 : cur_cap);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 16 * cap * es);
      default: return $urandom_range(0, 16 * cap - 1) % ($urandom_range(1, 3) * cap) * es;
    endcase
  endfunction

  task automatic run_phase(input int count);
    int burst;
    int r;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_request(OP_ALLOC, $urandom());
        else if (r < 95) send_request(OP_DISPOSE, pick_address());
        else if (r < 98) send_request(OP_CLEAR, $urandom());
        else send_request(OP_NONE, $urandom());
        burst--;
        count--;
      end
      idle_gap();
    end
  endtask

  initial begin
    logic [12:0] sizes [6];
    logic [12:0] caps [6];
    sizes = '{13'd16, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd24};
    caps  = '{13'd256, 13'd1, 13'd3, 13'd0, 13'd511, 13'd17};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: allocate, double dispose, bad addresses, clear, unused op
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF);
    send_request(OP_DISPOSE, 32'd16);
    send_request(OP_DISPOSE, 32'd16);
    send_request(OP_DISPOSE, 32'd17);
    send_request(OP_DISPOSE, 32'hFFFF_FFFF);
    send_request(OP_DISPOSE, 32'd4096);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_CLEAR, 32'h0);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_NONE, 32'hFFFF_FFFF);
    drain();
    // tiny sections fill the pool quickly
    write_reg(REG_SECTION_CAPACITY, 13'd1);
    write_reg(REG_ELEMENT_SIZE, 13'd4096);
    repeat (18) send_request(OP_ALLOC, 32'h0);
    send_request(OP_DISPOSE, 32'd4096 * 5);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_DISPOSE, 32'd4096 * 16);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ELEMENT_SIZE, sizes[p]);
      write_reg(REG_SECTION_CAPACITY, caps[p]);
      run_phase(250);
      drain();
    end
    $display("requests sent: %0d, pool full %0d, invalid %0d, already free %0d",
             sent, seen_full, seen_invalid, seen_already);
    $display("covered six register settings including extremes and out of range values");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
